>>> rtl/core/led_pattern_generator_core_defines.svh
// assertion helpers used by the core rtl
`ifndef LED_PATTERN_GENERATOR_CORE_DEFINES_SVH
`define LED_PATTERN_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lpg_pkg.sv
package lpg_pkg;

    // width of the elapsed millisecond counter
    localparam int TIME_WIDTH = 16;
    // width of the interval registers
    localparam int CFG_WIDTH  = 16;
    // width used for threshold compares
    localparam int CMP_WIDTH  = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

    localparam int ADDR_WIDTH = 5;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_WIDTH  = 3;

    typedef enum logic [2:0] {
        MODE_OFF       = 3'd0,
        MODE_STEADY    = 3'd1,
        MODE_SLOW      = 3'd2,
        MODE_FAST      = 3'd3,
        MODE_DOUBLE    = 3'd4,
        MODE_HEARTBEAT = 3'd5,
        MODE_ERROR     = 3'd6,
        MODE_TRIPLE    = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        REG_MODE       = 3'd0,
        REG_SLOW       = 3'd1,
        REG_FAST       = 3'd2,
        REG_PULSE      = 3'd3,
        REG_BURST_PAUSE = 3'd4,
        REG_ERROR_PAUSE = 3'd5,
        REG_HB_ON      = 3'd6,
        REG_HB_PERIOD  = 3'd7
    } t_reg_idx;

    localparam logic [CFG_WIDTH-1:0] SLOW_RESET        = CFG_WIDTH'(900);
    localparam logic [CFG_WIDTH-1:0] FAST_RESET        = CFG_WIDTH'(100);
    localparam logic [CFG_WIDTH-1:0] PULSE_RESET       = CFG_WIDTH'(120);
    localparam logic [CFG_WIDTH-1:0] BURST_PAUSE_RESET = CFG_WIDTH'(800);
    localparam logic [CFG_WIDTH-1:0] ERROR_PAUSE_RESET = CFG_WIDTH'(1500);
    localparam logic [CFG_WIDTH-1:0] HB_ON_RESET       = CFG_WIDTH'(80);
    localparam logic [CFG_WIDTH-1:0] HB_PERIOD_RESET   = CFG_WIDTH'(1000);

    // toggles per burst
    localparam logic [CNT_WIDTH-1:0] DOUBLE_LIMIT = CNT_WIDTH'(4);
    localparam logic [CNT_WIDTH-1:0] LONG_LIMIT   = CNT_WIDTH'(6);

    typedef struct packed {
        t_mode                 mode;
        logic [CFG_WIDTH-1:0]  slow_interval;
        logic [CFG_WIDTH-1:0]  fast_interval;
        logic [CFG_WIDTH-1:0]  pulse_interval;
        logic [CFG_WIDTH-1:0]  burst_pause;
        logic [CFG_WIDTH-1:0]  error_pause;
        logic [CFG_WIDTH-1:0]  heartbeat_on;
        logic [CFG_WIDTH-1:0]  heartbeat_period;
    } t_cfg;

endpackage

>>> rtl/core/lpg_regs.sv
module lpg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lpg_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [lpg_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [lpg_pkg::DATA_WIDTH-1:0] prdata,
    output lpg_pkg::t_cfg                  o_cfg
);

    lpg_pkg::t_cfg      r_cfg;
    lpg_pkg::t_reg_idx  w_idx;
    logic               w_wr;
    logic [lpg_pkg::CFG_WIDTH-1:0] w_v16;

    assign w_idx = lpg_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr  = psel & penable & pwrite;
    assign w_v16 = pwdata[lpg_pkg::CFG_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode             <= lpg_pkg::MODE_OFF;
            r_cfg.slow_interval    <= lpg_pkg::SLOW_RESET;
            r_cfg.fast_interval    <= lpg_pkg::FAST_RESET;
            r_cfg.pulse_interval   <= lpg_pkg::PULSE_RESET;
            r_cfg.burst_pause      <= lpg_pkg::BURST_PAUSE_RESET;
            r_cfg.error_pause      <= lpg_pkg::ERROR_PAUSE_RESET;
            r_cfg.heartbeat_on     <= lpg_pkg::HB_ON_RESET;
            r_cfg.heartbeat_period <= lpg_pkg::HB_PERIOD_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                lpg_pkg::REG_MODE:        r_cfg.mode <= lpg_pkg::t_mode'(pwdata[2:0]);
                lpg_pkg::REG_SLOW:        r_cfg.slow_interval    <= w_v16;
                lpg_pkg::REG_FAST:        r_cfg.fast_interval    <= w_v16;
                lpg_pkg::REG_PULSE:       r_cfg.pulse_interval   <= w_v16;
                lpg_pkg::REG_BURST_PAUSE: r_cfg.burst_pause      <= w_v16;
                lpg_pkg::REG_ERROR_PAUSE: r_cfg.error_pause      <= w_v16;
                lpg_pkg::REG_HB_ON:       r_cfg.heartbeat_on     <= w_v16;
                lpg_pkg::REG_HB_PERIOD:   r_cfg.heartbeat_period <= w_v16;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            lpg_pkg::REG_MODE:        prdata = lpg_pkg::DATA_WIDTH'(r_cfg.mode);
            lpg_pkg::REG_SLOW:        prdata = lpg_pkg::DATA_WIDTH'(r_cfg.slow_interval);
            lpg_pkg::REG_FAST:        prdata = lpg_pkg::DATA_WIDTH'(r_cfg.fast_interval);
            lpg_pkg::REG_PULSE:       prdata = lpg_pkg::DATA_WIDTH'(r_cfg.pulse_interval);
            lpg_pkg::REG_BURST_PAUSE: prdata = lpg_pkg::DATA_WIDTH'(r_cfg.burst_pause);
            lpg_pkg::REG_ERROR_PAUSE: prdata = lpg_pkg::DATA_WIDTH'(r_cfg.error_pause);
            lpg_pkg::REG_HB_ON:       prdata = lpg_pkg::DATA_WIDTH'(r_cfg.heartbeat_on);
            lpg_pkg::REG_HB_PERIOD:   prdata = lpg_pkg::DATA_WIDTH'(r_cfg.heartbeat_period);
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/lpg_engine.sv
module lpg_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic          i_tick,
    input  lpg_pkg::t_cfg i_cfg,
    output logic          o_led_next
);

    localparam int TW = lpg_pkg::TIME_WIDTH;
    localparam int CW = lpg_pkg::CMP_WIDTH;
    localparam int NW = lpg_pkg::CNT_WIDTH;

    logic [TW-1:0] r_elapsed, n_elapsed;
    logic [NW-1:0] r_count, n_count;
    logic          r_level, n_level;
    logic          r_pin, n_pin;
    logic          r_pause, n_pause;

    always_comb begin
        logic [CW-1:0] el;
        logic [CW-1:0] interval;
        logic [CW-1:0] pause;
        logic [NW-1:0] limit;
        logic [NW-1:0] cnt_inc;
        logic          force_low;
        logic          is_burst;
        n_elapsed = r_elapsed;
        n_count   = r_count;
        n_level   = r_level;
        n_pin     = r_pin;
        n_pause   = r_pause;
        interval  = CW'(i_cfg.pulse_interval);
        pause     = CW'(i_cfg.burst_pause);
        limit     = lpg_pkg::LONG_LIMIT;
        force_low = 1'b1;
        is_burst  = 1'b0;
        cnt_inc   = r_count + NW'(1);
        // saturating increment
        if (r_elapsed != {TW{1'b1}}) begin
            n_elapsed = r_elapsed + TW'(1);
        end
        el = CW'(n_elapsed);
        case (i_cfg.mode)
            lpg_pkg::MODE_OFF: begin
                n_level = 1'b0;
                n_pin   = 1'b0;
            end
            lpg_pkg::MODE_STEADY: begin
                n_level = 1'b1;
                n_pin   = 1'b1;
            end
            lpg_pkg::MODE_SLOW: interval = CW'(i_cfg.slow_interval);
            lpg_pkg::MODE_FAST: interval = CW'(i_cfg.fast_interval);
            lpg_pkg::MODE_DOUBLE: begin
                is_burst  = 1'b1;
                limit     = lpg_pkg::DOUBLE_LIMIT;
                force_low = 1'b0;
            end
            lpg_pkg::MODE_HEARTBEAT: begin
                if (el >= CW'(i_cfg.heartbeat_period)) begin
                    n_elapsed = '0;
                    n_pin     = 1'b1;
                end else if (el >= CW'(i_cfg.heartbeat_on)) begin
                    n_pin = 1'b0;
                end
            end
            lpg_pkg::MODE_ERROR: begin
                is_burst = 1'b1;
                pause    = CW'(i_cfg.error_pause);
            end
            default: is_burst = 1'b1;
        endcase
        // end of burst pause
        if (is_burst && r_pause && el >= pause) begin
            el        = el - pause;
            n_elapsed = el[TW-1:0];
            n_pause   = 1'b0;
        end
        // timed toggle for blink and burst modes
        if ((i_cfg.mode == lpg_pkg::MODE_SLOW || i_cfg.mode == lpg_pkg::MODE_FAST
                || (is_burst && !n_pause)) && el >= interval) begin
            n_elapsed = '0;
            n_level   = ~r_level;
            n_pin     = ~r_level;
            if (is_burst) begin
                if (cnt_inc >= limit) begin
                    n_count = '0;
                    n_pause = 1'b1;
                    if (force_low) begin
                        n_pin = 1'b0;
                    end
                end else begin
                    n_count = cnt_inc;
                end
            end
        end
        // no tick: hold everything
        if (!i_tick) begin
            n_elapsed = r_elapsed;
            n_count   = r_count;
            n_level   = r_level;
            n_pin     = r_pin;
            n_pause   = r_pause;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_count   <= '0;
            r_level   <= 1'b0;
            r_pin     <= 1'b0;
            r_pause   <= 1'b0;
        end else if (i_fire) begin
            r_elapsed <= n_elapsed;
            r_count   <= n_count;
            r_level   <= n_level;
            r_pin     <= n_pin;
            r_pause   <= n_pause;
        end
    end

    assign o_led_next = n_pin;

endmodule

>>> rtl/core/led_pattern_generator_core.sv
// LED pattern generator: each input beat carries one millisecond tick and yields one
// output beat with the LED level after that tick. Modes are off, steady, slow blink,
// fast blink, double blink, heartbeat, error pulse and triple blink, chosen with the
// mode register; intervals and pauses are in ticks. A beat with tick low leaves the
// pattern state untouched and repeats the current level. One beat is accepted every
// clock cycle while the skid entry is empty: the pattern state updates on the
// accepted beat and the level goes to an output register backed by a one-entry skid
// buffer, so the input side keeps flowing while a result waits.
// Registers sit on an apb-style port at byte address 4 * index, always ready, and are
// to be written only while no beats are in flight.
`include "led_pattern_generator_core_defines.svh"

module led_pattern_generator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input beat channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_tick,
    // output beat channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_led_on,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lpg_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [lpg_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [lpg_pkg::DATA_WIDTH-1:0] prdata,
    output logic                           pready
);

    lpg_pkg::t_cfg w_cfg;
    logic          w_led_next;
    logic          w_in_fire;
    logic          w_out_fire;
    logic          w_slot_free;

    // output register and skid entry
    logic          r_out_valid;
    logic          r_out_led;
    logic          r_skid_valid;
    logic          r_skid_led;

    assign pready = 1'b1;

    lpg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    // pattern state, advanced once per accepted beat
    lpg_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_in_fire),
        .i_tick     (i_tick),
        .i_cfg      (w_cfg),
        .o_led_next (w_led_next)
    );

    // ready depends only on the skid entry, so no combinational path from i_out_ready
    assign o_in_ready  = ~r_skid_valid;
    assign w_in_fire   = i_in_valid & o_in_ready;
    assign w_out_fire  = r_out_valid & i_out_ready;
    // output register can take a new level this cycle
    assign w_slot_free = ~r_out_valid | w_out_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_slot_free) begin
            if (r_skid_valid) begin
                // drain the skid entry first to keep beat order
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_fire;
            end
        end else if (w_in_fire) begin
            // output stalled: park the new level
            r_skid_valid <= 1'b1;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_slot_free) begin
            r_out_led <= r_skid_valid ? r_skid_led : w_led_next;
        end
        if (!w_slot_free && w_in_fire) begin
            r_skid_led <= w_led_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led_on    = r_out_led;

    // skid entry only fills behind a held output beat
    `LPG_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid valid while output empty")

    // a beat accepted against a stalled output must land in the skid entry
    `LPG_ASSERT_NXT(a_stall_parks, i_clk, i_rst_n, w_in_fire && r_out_valid && !i_out_ready, r_skid_valid, "stalled beat not parked")

    // off mode drives the led low on every tick
    `LPG_ASSERT_IMP(a_off_is_dark, i_clk, i_rst_n, w_in_fire && i_tick && (w_cfg.mode == lpg_pkg::MODE_OFF), !w_led_next, "led lit in off mode")

    // a drained skid entry leaves a valid output beat behind
    `LPG_ASSERT_NXT(a_drain_keeps_out, i_clk, i_rst_n, r_skid_valid && w_out_fire, r_out_valid && !r_skid_valid, "skid drain lost a beat")

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

import lpg_pkg::*;

// tracks the led level that each accepted tick beat must produce
class led_scoreboard;
    t_mode                 mode;
    logic [CFG_WIDTH-1:0]  slow_iv;
    logic [CFG_WIDTH-1:0]  fast_iv;
    logic [CFG_WIDTH-1:0]  pulse_iv;
    logic [CFG_WIDTH-1:0]  burst_ps;
    logic [CFG_WIDTH-1:0]  error_ps;
    logic [CFG_WIDTH-1:0]  hb_on;
    logic [CFG_WIDTH-1:0]  hb_period;

    logic [TIME_WIDTH-1:0] elapsed;
    logic [CNT_WIDTH-1:0]  toggles;
    logic                  phase;
    logic                  pin;
    logic                  pausing;

    logic                  led_due[$];
    int                    errors;
    int                    beats_seen;

    function new();
        mode      = MODE_OFF;
        slow_iv   = SLOW_RESET;
        fast_iv   = FAST_RESET;
        pulse_iv  = PULSE_RESET;
        burst_ps  = BURST_PAUSE_RESET;
        error_ps  = ERROR_PAUSE_RESET;
        hb_on     = HB_ON_RESET;
        hb_period = HB_PERIOD_RESET;
        elapsed   = '0;
        toggles   = '0;
        phase     = 1'b0;
        pin       = 1'b0;
        pausing   = 1'b0;
        errors    = 0;
        beats_seen = 0;
    endfunction

    function void set_reg(t_reg_idx idx, logic [CFG_WIDTH-1:0] value);
        case (idx)
            REG_MODE:        mode      = t_mode'(value[2:0]);
            REG_SLOW:        slow_iv   = value;
            REG_FAST:        fast_iv   = value;
            REG_PULSE:       pulse_iv  = value;
            REG_BURST_PAUSE: burst_ps  = value;
            REG_ERROR_PAUSE: error_ps  = value;
            REG_HB_ON:       hb_on     = value;
            default:         hb_period = value;
        endcase
    endfunction

    function int pending();
        return led_due.size();
    endfunction

    function bit toggle_due(logic [CFG_WIDTH-1:0] iv);
        if (elapsed < iv) return 1'b0;
        elapsed = '0;
        phase   = ~phase;
        pin     = phase;
        return 1'b1;
    endfunction

    function void run_burst(logic [CNT_WIDTH-1:0] limit, logic [CFG_WIDTH-1:0] pause,
                            bit force_low);
        if (pausing && elapsed >= pause) begin
            elapsed = elapsed - pause;
            pausing = 1'b0;
        end
        if (!pausing) begin
            if (toggle_due(pulse_iv)) begin
                if (int'(toggles) + 1 >= int'(limit)) begin
                    toggles = '0;
                    pausing = 1'b1;
                    if (force_low) pin = 1'b0;
                end else begin
                    toggles = toggles + 1'b1;
                end
            end
        end
    endfunction

    function void note_tick(logic tick);
        if (tick) begin
            if (elapsed != '1) elapsed = elapsed + 1'b1;
            case (mode)
                MODE_OFF: begin
                    phase = 1'b0;
                    pin   = 1'b0;
                end
                MODE_STEADY: begin
                    phase = 1'b1;
                    pin   = 1'b1;
                end
                MODE_SLOW:   void'(toggle_due(slow_iv));
                MODE_FAST:   void'(toggle_due(fast_iv));
                MODE_DOUBLE: run_burst(DOUBLE_LIMIT, burst_ps, 1'b0);
                MODE_HEARTBEAT: begin
                    if (elapsed >= hb_period) begin
                        elapsed = '0;
                        pin     = 1'b1;
                    end else if (elapsed >= hb_on) begin
                        pin = 1'b0;
                    end
                end
                MODE_ERROR:  run_burst(LONG_LIMIT, error_ps, 1'b1);
                default:     run_burst(LONG_LIMIT, burst_ps, 1'b1);
            endcase
        end
        led_due.push_back(pin);
    endfunction

    task report(string what);
        if (errors < 40) $display("mismatch at beat %0d: %s", beats_seen, what);
        errors++;
    endtask

    task check_led(logic led);
        logic want;
        beats_seen++;
        if (led_due.size() == 0) begin
            report($sformatf("led beat %0b with no tick pending", led));
            return;
        end
        want = led_due.pop_front();
        if (led !== want) report($sformatf("led_on %0b, expected %0b", led, want));
    endtask
endclass

module tb;

    // generous bound for the directed and random parts under heavy stalls
    localparam int CYCLE_LIMIT    = 100000;
    localparam int RANDOM_TICKS   = 1300;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_tick      = 1'b0;
    logic                  i_out_ready = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr       = '0;
    logic [DATA_WIDTH-1:0] pwdata      = '0;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_led_on;

    // idle odds in percent for the sending and the receiving side
    int send_idle_pct  = 9;
    int recv_stall_pct = 58;
    int cycles         = 0;

    led_scoreboard sb;

    led_pattern_generator_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_tick      (i_tick),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_led_on    (o_led_on),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog, also catches results that never show up
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // output beats are compared against the oldest predicted level
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_led(o_led_on);
    end

    // one tick beat; valid stays up from the first drive until the handshake
    task automatic send_beat(input logic tick);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_tick     <= tick;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_tick(tick);
    endtask

    task automatic send_run(input int count, input logic tick);
        repeat (count) send_beat(tick);
    endtask

    // stop sending and wait out every outstanding level
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // setup, access and then idle phase, so psel is never re-raised in one step
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_WIDTH'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly short spans so bursts and pauses finish within a phase, some extremes
    function automatic logic [CFG_WIDTH-1:0] pick_span();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) return '1;
        if (pick < 12) return CFG_WIDTH'($urandom);
        return CFG_WIDTH'($urandom_range(0, 14));
    endfunction

    initial begin
        int ticks_sent;
        int phase_len;
        sb = new();
        ticks_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings in off mode, then a held beat with no tick
        send_run(1, 1'b1);
        send_run(1, 1'b0);
        settle();
        write_reg(REG_MODE, CFG_WIDTH'(MODE_STEADY));
        send_run(2, 1'b1);
        send_run(1, 1'b0);
        settle();

        // zero interval toggles on every tick
        write_reg(REG_FAST, '0);
        write_reg(REG_MODE, CFG_WIDTH'(MODE_FAST));
        send_run(3, 1'b1);
        settle();
        write_reg(REG_SLOW, CFG_WIDTH'(1));
        write_reg(REG_MODE, CFG_WIDTH'(MODE_SLOW));
        send_run(2, 1'b1);
        send_run(1, 1'b0);
        settle();

        // double burst with zero pause: the pause ends on the very next tick
        write_reg(REG_PULSE, '0);
        write_reg(REG_BURST_PAUSE, '0);
        write_reg(REG_MODE, CFG_WIDTH'(MODE_DOUBLE));
        send_run(5, 1'b1);
        settle();
        write_reg(REG_HB_ON, CFG_WIDTH'(1));
        write_reg(REG_HB_PERIOD, CFG_WIDTH'(3));
        write_reg(REG_MODE, CFG_WIDTH'(MODE_HEARTBEAT));
        send_run(3, 1'b1);
        settle();

        // error burst forces the pin low at its end; triple picks up the shared count
        write_reg(REG_ERROR_PAUSE, CFG_WIDTH'(1));
        write_reg(REG_MODE, CFG_WIDTH'(MODE_ERROR));
        send_run(7, 1'b1);
        settle();
        write_reg(REG_MODE, CFG_WIDTH'(MODE_TRIPLE));
        send_run(4, 1'b1);

        // random phases; state carries across mode changes on purpose
        while (ticks_sent < RANDOM_TICKS) begin
            settle();
            if (ticks_sent < RANDOM_TICKS / 3) begin
                send_idle_pct  = 9;
                recv_stall_pct = 58;
            end else if (ticks_sent < 2 * RANDOM_TICKS / 3) begin
                send_idle_pct  = 58;
                recv_stall_pct = 9;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            for (int r = 1; r < 8; r++) begin
                if ($urandom_range(99) < 40) write_reg(t_reg_idx'(r), pick_span());
            end
            write_reg(REG_MODE, CFG_WIDTH'($urandom_range(7)));
            phase_len = $urandom_range(10, 90);
            repeat (phase_len) send_beat($urandom_range(99) >= 15);
            ticks_sent += phase_len;
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/lpg_pkg.sv
rtl/core/lpg_regs.sv
rtl/core/lpg_engine.sv
rtl/core/led_pattern_generator_core.sv
verif/tb.sv
